### src/sdcmd_pkg.sv
`timescale 1ns / 1ps
// Shared types and codes for the SD-card SPI command engine.
// Used by the front end, the request queue, the sequencer and the top level.
package sdcmd_pkg;

    // Operation codes on the input channel.
    localparam logic [1:0] OP_ISSUE   = 2'd0;
    localparam logic [1:0] OP_RX_BYTE = 2'd1;
    localparam logic [1:0] OP_RELEASE = 2'd2;

    // Request classes produced by the front end.
    localparam logic [1:0] REQ_ISSUE   = 2'd0;
    localparam logic [1:0] REQ_RX_BYTE = 2'd1;
    localparam logic [1:0] REQ_RELEASE = 2'd2;
    localparam logic [1:0] REQ_BAD     = 2'd3;

    // Result kinds.
    localparam logic [1:0] KIND_SEND   = 2'd0;
    localparam logic [1:0] KIND_DONE   = 2'd1;
    localparam logic [1:0] KIND_REJECT = 2'd2;

    localparam logic [2:0] MAX_TRAILING = 3'd4;

    typedef struct packed {
        logic [1:0]  cls;
        logic [5:0]  cmd_index;
        logic        app_command;
        logic [31:0] argument;
        logic [2:0]  trailing_len;
        logic [7:0]  rx_byte;
    } sdcmd_req_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  tx_byte;
        logic        chip_select;
        logic [7:0]  r1_response;
        logic [31:0] trailing_data;
        logic        response_timeout;
    } sdcmd_result_t;

endpackage

### src/sdcmd_front.sv
`timescale 1ns / 1ps
// Front end: classifies incoming requests and normalizes their fields.
// Depends on sdcmd_pkg.
module sdcmd_front
(
    input  logic [1:0]          operation,
    input  logic [5:0]          cmd_index,
    input  logic                app_command,
    input  logic [31:0]         argument,
    input  logic [2:0]          trailing_len,
    input  logic [7:0]          rx_byte,
    output sdcmd_pkg::sdcmd_req_t req
);

    logic [1:0] cls;

    always_comb
    begin
        case (operation)
            sdcmd_pkg::OP_ISSUE:   cls = sdcmd_pkg::REQ_ISSUE;
            sdcmd_pkg::OP_RX_BYTE: cls = sdcmd_pkg::REQ_RX_BYTE;
            sdcmd_pkg::OP_RELEASE: cls = sdcmd_pkg::REQ_RELEASE;
            default:               cls = sdcmd_pkg::REQ_BAD;
        endcase
    end

    always_comb
    begin
        req.cls          = cls;
        req.cmd_index    = cmd_index;
        req.app_command  = app_command;
        req.argument     = argument;
        // Lengths above four saturate.
        req.trailing_len = (trailing_len > sdcmd_pkg::MAX_TRAILING) ?
                           sdcmd_pkg::MAX_TRAILING : trailing_len;
        req.rx_byte      = rx_byte;
    end

endmodule

### src/sdcmd_queue.sv
`timescale 1ns / 1ps
// Small request queue between the front end and the sequencer.
// Depends on sdcmd_pkg.
module sdcmd_queue
#(
    parameter int DEPTH = 4
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    input  sdcmd_pkg::sdcmd_req_t         push_data,
    input  logic                          pop,
    output sdcmd_pkg::sdcmd_req_t         head,
    output logic                          not_empty,
    output logic                          full,
    output logic [$clog2(DEPTH+1)-1:0]    count
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);

    sdcmd_pkg::sdcmd_req_t entries_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign head      = entries_reg[rd_ptr_reg];
    assign not_empty = (count_reg != '0);
    assign full      = (count_reg == CW'(DEPTH));
    assign count     = count_reg;

endmodule

### src/sdcmd_back.sv
`timescale 1ns / 1ps
// Sequencer: runs the SPI command byte sequence, one queued request per cycle
// while its output is not stalled, and registers the result. Depends on sdcmd_pkg.
module sdcmd_back
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic [7:0]               retries,
    input  logic                     req_valid,
    input  sdcmd_pkg::sdcmd_req_t    req,
    output logic                     pop,
    input  logic                     out_stall,
    output logic                     out_valid,
    output sdcmd_pkg::sdcmd_result_t result
);

    localparam logic [3:0] PH_IDLE  = 4'd0;
    localparam logic [3:0] PH_SEL   = 4'd1;
    localparam logic [3:0] PH_READY = 4'd2;
    localparam logic [3:0] PH_SEND  = 4'd3;
    localparam logic [3:0] PH_STUFF = 4'd4;
    localparam logic [3:0] PH_POLL  = 4'd5;
    localparam logic [3:0] PH_TRAIL = 4'd6;
    localparam logic [3:0] PH_REL   = 4'd7;

    localparam logic [5:0] CMD_GO_IDLE   = 6'd0;
    localparam logic [5:0] CMD_IF_COND   = 6'd8;
    localparam logic [5:0] CMD_STOP      = 6'd12;
    localparam logic [5:0] CMD_APP       = 6'd55;
    localparam logic [7:0] CRC_GO_IDLE   = 8'h95;
    localparam logic [7:0] CRC_IF_COND   = 8'h87;
    localparam logic [7:0] CRC_DUMMY     = 8'h01;
    localparam logic [7:0] FILL_BYTE     = 8'hFF;
    localparam logic [7:0] R1_IDLE       = 8'h01;
    localparam logic [2:0] LAST_PKT_BYTE = 3'd5;

    function automatic logic [7:0] packet_byte(input logic [5:0] c,
                                               input logic [31:0] arg,
                                               input logic [2:0] k);
        logic [7:0] b;
        case (k)
            3'd0: b = {2'b01, c};
            3'd1: b = arg[31:24];
            3'd2: b = arg[23:16];
            3'd3: b = arg[15:8];
            3'd4: b = arg[7:0];
            default:
            begin
                if (c == CMD_GO_IDLE)
                    b = CRC_GO_IDLE;
                else if (c == CMD_IF_COND)
                    b = CRC_IF_COND;
                else
                    b = CRC_DUMMY;
            end
        endcase
        return b;
    endfunction

    logic [3:0]  phase_reg, phase_next;
    logic [5:0]  cmd_reg, cmd_next;
    logic        app_reg, app_next;
    logic [31:0] arg_reg, arg_next;
    logic [2:0]  bc_reg, bc_next;
    logic [7:0]  poll_reg, poll_next;
    logic [2:0]  tc_reg, tc_next;
    logic [31:0] shift_reg, shift_next;
    logic [7:0]  r1_reg, r1_next;
    logic        cs_reg, cs_next;
    logic        out_valid_reg, out_valid_next;
    sdcmd_pkg::sdcmd_result_t res_reg, res_next;

    logic        start;
    logic        fin;
    logic        reject;
    logic [5:0]  act_cur;
    logic [31:0] arg_cur;
    logic [5:0]  act_new;
    logic [2:0]  tc_dec;

    assign pop = req_valid && (!out_valid_reg || !out_stall);

    always_comb
    begin
        phase_next = phase_reg;
        cmd_next   = cmd_reg;
        app_next   = app_reg;
        arg_next   = arg_reg;
        bc_next    = bc_reg;
        poll_next  = poll_reg;
        tc_next    = tc_reg;
        shift_next = shift_reg;
        r1_next    = r1_reg;
        cs_next    = cs_reg;
        start      = 1'b0;
        fin        = 1'b0;
        reject     = 1'b0;
        act_new    = '0;
        tc_dec     = tc_reg - 1'b1;
        act_cur    = app_reg ? CMD_APP : cmd_reg;
        arg_cur    = app_reg ? '0 : arg_reg;
        res_next   = '0;
        res_next.kind = sdcmd_pkg::KIND_SEND;

        if (pop)
        begin
            case (req.cls)
                sdcmd_pkg::REQ_ISSUE:
                begin
                    if (phase_reg != PH_IDLE)
                    begin
                        reject = 1'b1;
                    end
                    else
                    begin
                        cmd_next   = req.cmd_index;
                        app_next   = req.app_command;
                        arg_next   = req.argument;
                        tc_next    = req.trailing_len;
                        shift_next = '0;
                        r1_next    = '0;
                        bc_next    = '0;
                        poll_next  = '0;
                        start      = 1'b1;
                    end
                end
                sdcmd_pkg::REQ_RELEASE:
                begin
                    if (phase_reg != PH_IDLE)
                    begin
                        reject = 1'b1;
                    end
                    else
                    begin
                        cs_next          = 1'b0;
                        phase_next       = PH_REL;
                        res_next.tx_byte = FILL_BYTE;
                    end
                end
                sdcmd_pkg::REQ_RX_BYTE:
                begin
                    case (phase_reg)
                        PH_IDLE:
                        begin
                            reject = 1'b1;
                        end
                        PH_SEL:
                        begin
                            phase_next       = PH_READY;
                            res_next.tx_byte = FILL_BYTE;
                        end
                        PH_READY:
                        begin
                            if (req.rx_byte == FILL_BYTE)
                            begin
                                phase_next       = PH_SEND;
                                bc_next          = '0;
                                res_next.tx_byte = packet_byte(act_cur, arg_cur, 3'd0);
                            end
                            else
                            begin
                                res_next.tx_byte = FILL_BYTE;
                            end
                        end
                        PH_SEND:
                        begin
                            if (bc_reg < LAST_PKT_BYTE)
                            begin
                                bc_next          = bc_reg + 1'b1;
                                res_next.tx_byte = packet_byte(act_cur, arg_cur, bc_next);
                            end
                            else
                            begin
                                if (act_cur == CMD_STOP)
                                begin
                                    phase_next = PH_STUFF;
                                end
                                else
                                begin
                                    phase_next = PH_POLL;
                                    poll_next  = retries;
                                end
                                res_next.tx_byte = FILL_BYTE;
                            end
                        end
                        PH_STUFF:
                        begin
                            phase_next       = PH_POLL;
                            poll_next        = retries;
                            res_next.tx_byte = FILL_BYTE;
                        end
                        PH_POLL:
                        begin
                            if (req.rx_byte[7] && (poll_reg != '0))
                            begin
                                poll_next        = poll_reg - 1'b1;
                                res_next.tx_byte = FILL_BYTE;
                            end
                            else
                            begin
                                r1_next = req.rx_byte;
                                if (app_reg)
                                begin
                                    // CMD55 went through; only an idle R1 lets the
                                    // real command follow.
                                    app_next = 1'b0;
                                    if (req.rx_byte != R1_IDLE)
                                    begin
                                        fin = 1'b1;
                                    end
                                    else
                                    begin
                                        r1_next = '0;
                                        start   = 1'b1;
                                    end
                                end
                                else if (tc_reg == '0)
                                begin
                                    fin = 1'b1;
                                end
                                else
                                begin
                                    phase_next       = PH_TRAIL;
                                    res_next.tx_byte = FILL_BYTE;
                                end
                            end
                        end
                        PH_TRAIL:
                        begin
                            shift_next = {shift_reg[23:0], req.rx_byte};
                            if (tc_reg != '0)
                            begin
                                tc_next = tc_dec;
                            end
                            if (tc_next == '0)
                            begin
                                fin = 1'b1;
                            end
                            else
                            begin
                                res_next.tx_byte = FILL_BYTE;
                            end
                        end
                        PH_REL:
                        begin
                            phase_next    = PH_IDLE;
                            res_next.kind = sdcmd_pkg::KIND_DONE;
                        end
                        default:
                        begin
                            phase_next    = PH_IDLE;
                            res_next.kind = sdcmd_pkg::KIND_DONE;
                        end
                    endcase
                end
                default:
                begin
                    reject = 1'b1;
                end
            endcase

            if (start)
            begin
                act_new = app_next ? CMD_APP : cmd_next;
                if (act_new != CMD_STOP)
                begin
                    cs_next          = 1'b1;
                    phase_next       = PH_SEL;
                    res_next.tx_byte = FILL_BYTE;
                end
                else
                begin
                    // CMD12 skips the select and ready wait.
                    phase_next       = PH_SEND;
                    bc_next          = '0;
                    res_next.tx_byte = packet_byte(act_new,
                                                   app_next ? 32'd0 : arg_next, 3'd0);
                end
            end

            if (fin)
            begin
                phase_next                = PH_IDLE;
                res_next.kind             = sdcmd_pkg::KIND_DONE;
                res_next.tx_byte          = '0;
                res_next.r1_response      = r1_next;
                res_next.trailing_data    = shift_next;
                res_next.response_timeout = r1_next[7];
            end

            if (reject)
            begin
                phase_next    = phase_reg;
                res_next.kind = sdcmd_pkg::KIND_REJECT;
            end

            res_next.chip_select = cs_next;
        end
    end

    always_comb
    begin
        if (pop)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            cmd_reg       <= '0;
            app_reg       <= 1'b0;
            arg_reg       <= '0;
            bc_reg        <= '0;
            poll_reg      <= '0;
            tc_reg        <= '0;
            shift_reg     <= '0;
            r1_reg        <= '0;
            cs_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            cmd_reg       <= cmd_next;
            app_reg       <= app_next;
            arg_reg       <= arg_next;
            bc_reg        <= bc_next;
            poll_reg      <= poll_next;
            tc_reg        <= tc_next;
            shift_reg     <= shift_next;
            r1_reg        <= r1_next;
            cs_reg        <= cs_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            res_reg <= res_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign result    = res_reg;

endmodule

### src/sd_spi_command_engine_unit.sv
`timescale 1ns / 1ps
// SD-card SPI-mode command engine, one request per SPI byte exchange.
// Throughput: one request accepted per cycle, stalled only while the request queue is
// full; the sequencer retires one queued request per cycle, set by its single state update,
// unless out_stall holds a valid result. A request is written into the queue when
// accepted; the sequencer pops it and registers its result. Reset (rst_n, async)
// empties the queue, idles the sequencer, deasserts chip select, retries = 10.
module sd_spi_command_engine_unit
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [7:0]  cfg_wdata,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  operation,
    input  logic [5:0]  cmd_index,
    input  logic        app_command,
    input  logic [31:0] argument,
    input  logic [2:0]  trailing_len,
    input  logic [7:0]  rx_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  kind,
    output logic [7:0]  tx_byte,
    output logic        chip_select,
    output logic [7:0]  r1_response,
    output logic [31:0] trailing_data,
    output logic        response_timeout
);

    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [7:0] RETRIES_RESET = 8'd10;

    logic [7:0]               retries_reg;
    sdcmd_pkg::sdcmd_req_t    front_req;
    sdcmd_pkg::sdcmd_req_t    q_head;
    logic                     q_not_empty;
    logic                     q_full;
    logic [CW-1:0]            q_count;
    logic                     q_push;
    logic                     q_pop;
    sdcmd_pkg::sdcmd_result_t result;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            retries_reg <= RETRIES_RESET;
        else if (cfg_we)
            retries_reg <= cfg_wdata;
    end

    sdcmd_front u_front
    (
        .operation    (operation),
        .cmd_index    (cmd_index),
        .app_command  (app_command),
        .argument     (argument),
        .trailing_len (trailing_len),
        .rx_byte      (rx_byte),
        .req          (front_req)
    );

    assign in_stall = q_full;
    assign q_push   = in_valid && !q_full;

    sdcmd_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (front_req),
        .pop       (q_pop),
        .head      (q_head),
        .not_empty (q_not_empty),
        .full      (q_full),
        .count     (q_count)
    );

    sdcmd_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .retries   (retries_reg),
        .req_valid (q_not_empty),
        .req       (q_head),
        .pop       (q_pop),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .result    (result)
    );

    assign kind             = result.kind;
    assign tx_byte          = result.tx_byte;
    assign chip_select      = result.chip_select;
    assign r1_response      = result.r1_response;
    assign trailing_data    = result.trailing_data;
    assign response_timeout = result.response_timeout;

    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        q_count <= CW'(QUEUE_DEPTH))
        else $error("request queue count exceeds its depth");

    a_queue_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (q_push && !q_pop) |=> (q_count == $past(q_count) + 1'b1))
        else $error("request queue count did not follow a push");

    a_reject_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && kind == sdcmd_pkg::KIND_REJECT) |->
        (tx_byte == 8'd0 && r1_response == 8'd0 && trailing_data == 32'd0
         && !response_timeout))
        else $error("rejected request carries payload");

    a_done_no_tx: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && kind == sdcmd_pkg::KIND_DONE) |-> (tx_byte == 8'd0))
        else $error("completion carries a transmit byte");

endmodule
